### src/dhkt_pkg.sv
// Package for the double hash key table: sizes, command codes, queue entry type, back-end states.
// No dependencies.
package dhkt_pkg;
	localparam int TableSlots = 1021;
	localparam int ValueBits = 64;
	localparam int SlotBits = $clog2(TableSlots);
	localparam int CountBits = $clog2(TableSlots + 1);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [31:0]          key;
		logic [ValueBits-1:0] value;
		logic [9:0]           slot_in;
		logic [SlotBits-1:0]  base;
		logic [SlotBits-1:0]  step;
		logic                 bad;
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_CHECK, ST_WRITE, ST_DONE
	} state_t;
endpackage

### src/dhkt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dhkt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### src/dhkt_front.sv
// Front end: accepts requests, works out the probe base and step by folding the key
// in 10-bit chunks (partial sums registered, then reduced), pushes into a two-entry queue. Uses dhkt_pkg.
module dhkt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dhkt_pkg::req_t  in_req,
	output logic            q_valid,
	input  logic            q_pop,
	output dhkt_pkg::req_t  q_head
);
	localparam int SB = dhkt_pkg::SlotBits;
	localparam int N = dhkt_pkg::TableSlots;
	localparam int CB = 16;
	// weights of the 10-bit key chunks: 2^10, 2^20, 2^30 reduced mod N and mod N-1
	localparam int A1 = (1 << 10) % N;
	localparam int A2 = (A1 * A1) % N;
	localparam int A3 = (A2 * A1) % N;
	localparam int B1 = (1 << 10) % (N - 1);
	localparam int B2 = (B1 * B1) % (N - 1);
	localparam int B3 = (B2 * B1) % (N - 1);

	dhkt_pkg::req_t cur_q;
	dhkt_pkg::req_t push_req;
	logic busy_q;
	logic ph_q;
	logic [CB-1:0] ra_q, rb_q;
	logic [CB-1:0] sa, sb, fa, fb;
	logic [SB-1:0] base_d, step_d;
	dhkt_pkg::req_t fifo_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic done;

	assign in_ready = !busy_q;
	assign q_valid = cnt_q != 2'd0;
	assign q_head = fifo_q[rd_q];
	assign done = busy_q && ph_q && cnt_q != 2'd2;

	// first step: weighted chunk sums; second: fold the high part once more and
	// subtract the modulus at most once (N sits just under 2^10)
	always_comb begin
		sa = CB'(cur_q.key[9:0]) + CB'(A1) * CB'(cur_q.key[19:10])
			+ CB'(A2) * CB'(cur_q.key[29:20]) + CB'(A3) * CB'(cur_q.key[31:30]);
		sb = CB'(cur_q.key[9:0]) + CB'(B1) * CB'(cur_q.key[19:10])
			+ CB'(B2) * CB'(cur_q.key[29:20]) + CB'(B3) * CB'(cur_q.key[31:30]);
		fa = CB'(ra_q[9:0]) + CB'(A1) * CB'(ra_q[CB-1:10]);
		fb = CB'(rb_q[9:0]) + CB'(B1) * CB'(rb_q[CB-1:10]);
		base_d = (fa >= CB'(N)) ? SB'(fa - CB'(N)) : fa[SB-1:0];
		step_d = ((fb >= CB'(N - 1)) ? SB'(fb - CB'(N - 1)) : fb[SB-1:0]) + SB'(1);
	end

	always_comb begin
		push_req = cur_q;
		push_req.base = base_d;
		push_req.step = step_d;
		push_req.bad = (cur_q.cmd == dhkt_pkg::CMD_READ)
			? (cur_q.slot_in >= 10'(N)) : (cur_q.key == 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= 1'b0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				ph_q <= 1'b0;
			end else if (busy_q && !ph_q) begin
				ph_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, done} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) cur_q <= in_req;
		if (busy_q && !ph_q) begin
			ra_q <= sa;
			rb_q <= sb;
		end
		if (done) fifo_q[wr_q] <= push_req;
	end
endmodule

### src/dhkt_back.sv
// Back end: probe sequencer over the key/value RAMs, clearing pass after reset,
// output register. Uses dhkt_pkg and dhkt_ram.
module dhkt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_pop,
	input  dhkt_pkg::req_t  q_head,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            ok,
	output logic [9:0]      slot_out,
	output logic [31:0]     key_out,
	output logic [63:0]     value_out,
	output logic [9:0]      entry_count
);
	localparam int SB = dhkt_pkg::SlotBits;
	localparam int VB = dhkt_pkg::ValueBits;
	localparam int N = dhkt_pkg::TableSlots;

	dhkt_pkg::state_t st_q, st_d;
	dhkt_pkg::req_t r_q;
	logic [SB-1:0] pos_q, addr;
	logic [SB:0] iter_q, psum;
	logic [dhkt_pkg::CountBits-1:0] cnt_q;
	logic we, hit, ins_hole;
	logic [31:0] kr, kw;
	logic [VB-1:0] vr, vw;

	dhkt_ram #(.Width(32), .Depth(N)) u_keys (
		.clk(clk), .we(we), .addr(addr), .wdata(kw), .rdata(kr));
	dhkt_ram #(.Width(VB), .Depth(N)) u_vals (
		.clk(clk), .we(we), .addr(addr), .wdata(vw), .rdata(vr));

	assign addr = pos_q;
	assign hit = kr != 32'd0 && kr == r_q.key;
	assign ins_hole = kr == 32'd0;
	assign psum = {1'b0, pos_q} + {1'b0, r_q.step};
	assign q_pop = st_q == dhkt_pkg::ST_IDLE && q_valid && !out_valid;

	always_comb begin
		st_d = st_q;
		case (st_q)
			dhkt_pkg::ST_CLEAR: if (pos_q == SB'(N - 1)) st_d = dhkt_pkg::ST_IDLE;
			dhkt_pkg::ST_IDLE: if (q_pop) st_d = dhkt_pkg::ST_READ;
			dhkt_pkg::ST_READ: st_d = r_q.bad ? dhkt_pkg::ST_DONE : dhkt_pkg::ST_CHECK;
			dhkt_pkg::ST_CHECK: begin
				if (r_q.cmd == dhkt_pkg::CMD_READ) st_d = dhkt_pkg::ST_DONE;
				else if (r_q.cmd == dhkt_pkg::CMD_INSERT && (hit || ins_hole))
					st_d = dhkt_pkg::ST_WRITE;
				else if (r_q.cmd == dhkt_pkg::CMD_REMOVE && hit) st_d = dhkt_pkg::ST_WRITE;
				else if (r_q.cmd == dhkt_pkg::CMD_LOOKUP && hit) st_d = dhkt_pkg::ST_DONE;
				else if (iter_q == (SB + 1)'(N - 1)) st_d = dhkt_pkg::ST_DONE;
				else st_d = dhkt_pkg::ST_READ;
			end
			dhkt_pkg::ST_WRITE: st_d = dhkt_pkg::ST_DONE;
			dhkt_pkg::ST_DONE: st_d = dhkt_pkg::ST_IDLE;
			default: st_d = dhkt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		kw = '0;
		vw = '0;
		case (st_q)
			dhkt_pkg::ST_CLEAR: we = 1'b1;
			dhkt_pkg::ST_WRITE: begin
				we = 1'b1;
				if (r_q.cmd == dhkt_pkg::CMD_INSERT) begin
					kw = r_q.key;
					vw = r_q.value[VB-1:0];
				end
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dhkt_pkg::ST_CLEAR;
			pos_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (st_q)
				dhkt_pkg::ST_CLEAR: if (pos_q != SB'(N - 1)) pos_q <= pos_q + SB'(1);
				dhkt_pkg::ST_IDLE: if (q_pop)
					pos_q <= (q_head.cmd == dhkt_pkg::CMD_READ) ? q_head.slot_in[SB-1:0]
						: q_head.base;
				dhkt_pkg::ST_CHECK: if (st_d == dhkt_pkg::ST_READ)
					pos_q <= (psum >= (SB + 1)'(N)) ? SB'(psum - (SB + 1)'(N)) : psum[SB-1:0];
				dhkt_pkg::ST_WRITE: begin
					if (r_q.cmd == dhkt_pkg::CMD_REMOVE)
						cnt_q <= cnt_q - dhkt_pkg::CountBits'(1);
					else if (key_out == 32'd0)
						cnt_q <= cnt_q + dhkt_pkg::CountBits'(1);
				end
				dhkt_pkg::ST_DONE: out_valid <= 1'b1;
				default: ;
			endcase
		end
	end

	// result fields, settled before the DONE cycle
	always_ff @(posedge clk) begin
		if (q_pop) begin
			r_q <= q_head;
			iter_q <= '0;
			ok <= 1'b0;
			slot_out <= '0;
			key_out <= '0;
			value_out <= '0;
		end
		if (st_q == dhkt_pkg::ST_CHECK) begin
			iter_q <= iter_q + (SB + 1)'(1);
			if (st_d != dhkt_pkg::ST_READ &&
			    (r_q.cmd == dhkt_pkg::CMD_READ ? !ins_hole : st_d != dhkt_pkg::ST_DONE || hit)) begin
				ok <= 1'b1;
				slot_out <= 10'(pos_q);
				key_out <= kr;
				value_out <= 64'(vr);
				if (r_q.cmd == dhkt_pkg::CMD_INSERT) begin
					key_out <= ins_hole ? 32'd0 : kr;
					value_out <= 64'(r_q.value[VB-1:0]);
				end
			end
		end
		if (st_q == dhkt_pkg::ST_WRITE && r_q.cmd == dhkt_pkg::CMD_INSERT) key_out <= r_q.key;
	end
	assign entry_count = 10'(cnt_q);
endmodule

### src/double_hash_key_table.sv
// Top level of the double hash key table: front end, request queue, back end.
// Depends on dhkt_pkg, dhkt_front, dhkt_back, dhkt_ram.
//
// An open-addressed table of 1021 key/value slots with double hashing. After reset
// a clearing pass over all slots empties the store before any request is served.
// The front end holds s_tready low after each accepted request while it folds the key
// into the probe base and step, then hands it to a two-entry queue once that has room.
// The back end probes one slot at a time through the single RAM port: it reads the slot
// in READ and tests it in CHECK, then WRITE for an insert or remove that succeeds and DONE
// for the result; a lookup or remove that misses probes all slots. A result that
// waits on m_tready holds the back end.
module double_hash_key_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: cmd[1:0], key[33:2], value[97:34], slot_in[107:98], zero pad to 112
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: ok[0], slot_out[10:1], key_out[42:11], value_out[106:43],
	// entry_count[116:107], zero pad to 120
	output logic [119:0] m_tdata
);
	dhkt_pkg::req_t in_req, q_head;
	logic q_valid, q_pop, ok;
	logic [9:0] slot_out, entry_count;
	logic [31:0] key_out;
	logic [63:0] value_out;

	always_comb begin
		in_req = '0;
		in_req.cmd = dhkt_pkg::cmd_t'(s_tdata[1:0]);
		in_req.key = s_tdata[33:2];
		in_req.value = s_tdata[97:34];
		in_req.slot_in = s_tdata[107:98];
	end

	dhkt_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head));

	dhkt_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
		.out_valid(m_tvalid), .out_ready(m_tready), .ok(ok), .slot_out(slot_out),
		.key_out(key_out), .value_out(value_out), .entry_count(entry_count));

	assign m_tdata = {3'd0, entry_count, value_out, key_out, slot_out, ok};

`ifndef ASSERT_OFF
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !ok |-> slot_out == 10'd0 && key_out == 32'd0)
		else $error("failed result carries data");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= 10'(dhkt_pkg::TableSlots))
		else $error("entry count out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
`endif
endmodule

### sim/double_hash_key_table_test.sv
// Testbench for double_hash_key_table: directed table, random request mix, then fill to full.
// Depends on dhkt_pkg and the RTL; predicts every response with an inline table model.
module double_hash_key_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] key;
		logic [63:0] value;
		logic [9:0]  slot_in;
	} op_t;

	typedef struct packed {
		logic        ok;
		logic [9:0]  slot;
		logic [31:0] key;
		logic [63:0] value;
		logic [9:0]  count;
	} resp_t;

	// directed row: request plus optional typed-in response
	typedef struct {
		op_t   op;
		bit    fixed;
		resp_t resp;
	} row_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [119:0] m_tdata;

	double_hash_key_table u_top (.*);

	always #5 clk = ~clk;

	// table model
	logic [31:0] tbl_key [dhkt_pkg::TableSlots];
	logic [63:0] tbl_val [dhkt_pkg::TableSlots];
	int          tbl_count;
	resp_t       pending_resp [$];
	int          fail_count = 0;
	int          resp_seen = 0;
	int          sent = 0;
	int          rx_wait = 0;
	longint      cycle = 0;
	bit          hard_mode = 0;
	logic [31:0] used_keys [$];

	function automatic int probe_at(logic [31:0] k, int i);
		longint b, s;
		b = longint'(k) % dhkt_pkg::TableSlots;
		s = longint'(k) % (dhkt_pkg::TableSlots - 1) + 1;
		return int'((b + longint'(i) * s) % dhkt_pkg::TableSlots);
	endfunction

	function automatic int first_copy(logic [31:0] k);
		int p;
		for (int i = 0; i < dhkt_pkg::TableSlots; i++) begin
			p = probe_at(k, i);
			if (tbl_key[p] != 0 && tbl_key[p] == k) return p;
		end
		return -1;
	endfunction

	function automatic resp_t table_apply(op_t op);
		resp_t r;
		int p;
		r = '{default: '0};
		case (dhkt_pkg::cmd_t'(op.cmd))
			dhkt_pkg::CMD_INSERT: if (op.key != 0) begin
				for (int i = 0; i < dhkt_pkg::TableSlots; i++) begin
					p = probe_at(op.key, i);
					if (tbl_key[p] == 0 || tbl_key[p] == op.key) begin
						if (tbl_key[p] == 0) begin
							tbl_key[p] = op.key;
							tbl_count++;
						end
						tbl_val[p] = op.value;
						r.ok = 1; r.slot = 10'(p); r.key = op.key; r.value = op.value;
						break;
					end
				end
			end
			dhkt_pkg::CMD_LOOKUP, dhkt_pkg::CMD_REMOVE: if (op.key != 0) begin
				p = first_copy(op.key);
				if (p >= 0) begin
					r.ok = 1; r.slot = 10'(p); r.key = tbl_key[p]; r.value = tbl_val[p];
					if (op.cmd == dhkt_pkg::CMD_REMOVE) begin
						tbl_key[p] = 0;
						tbl_val[p] = 0;
						if (tbl_count > 0) tbl_count--;
					end
				end
			end
			default: if (op.slot_in < dhkt_pkg::TableSlots && tbl_key[op.slot_in] != 0) begin
				r.ok = 1; r.slot = op.slot_in;
				r.key = tbl_key[op.slot_in]; r.value = tbl_val[op.slot_in];
			end
		endcase
		r.count = tbl_count[9:0];
		return r;
	endfunction

	// valid stays high across back-to-back requests; dropped for a gap or a drain
	task automatic send_op(op_t op, bit fixed, resp_t want);
		resp_t got;
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		got = table_apply(op);
		if (fixed && got != want)
			$display("directed row disagrees with table model at request %0d", sent);
		pending_resp.push_back(fixed ? want : got);
		s_tdata <= {4'b0, op.slot_in, op.value, op.key, op.cmd};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		do @(posedge clk); while (pending_resp.size() != 0);
	endtask

	function automatic logic [31:0] pick_key();
		if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		return $urandom();
	endfunction

	// response side
	always @(posedge clk) begin
		resp_t got, want;
		cycle <= cycle + 1;
		if (m_tvalid && m_tready) begin
			got.ok = m_tdata[0];
			got.slot = m_tdata[10:1];
			got.key = m_tdata[42:11];
			got.value = m_tdata[106:43];
			got.count = m_tdata[116:107];
			resp_seen++;
			if (pending_resp.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("unexpected response %h", m_tdata);
			end else begin
				want = pending_resp.pop_front();
				if (got != want) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"mismatch resp %0d: exp ok=%b slot=%0d key=%h val=%h cnt=%0d,",
							" got ok=%b slot=%0d key=%h val=%h cnt=%0d"},
							resp_seen, want.ok, want.slot, want.key, want.value, want.count,
							got.ok, got.slot, got.key, got.value, got.count);
				end
			end
			rx_wait = hard_mode ? 0 : $urandom_range(0, 18);
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		m_tready <= (rx_wait == 0);
	end

	always @(posedge clk) begin
		if (cycle > 64'd30_000_000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		row_t  rows [$];
		op_t   op;
		resp_t nil;
		int    roll;
		nil = '{default: '0};
		foreach (tbl_key[i]) begin
			tbl_key[i] = 0;
			tbl_val[i] = 0;
		end
		tbl_count = 0;
		// after reset: everything misses
		rows.push_back('{'{dhkt_pkg::CMD_LOOKUP, 32'd5, 64'd0, 10'd0}, 1, nil});
		rows.push_back('{'{dhkt_pkg::CMD_READ, 32'd0, 64'd0, 10'd0}, 1, nil});
		rows.push_back('{'{dhkt_pkg::CMD_REMOVE, 32'd77, 64'd0, 10'd0}, 1, nil});
		// key zero always fails
		rows.push_back('{'{dhkt_pkg::CMD_INSERT, 32'd0, 64'hFFFF, 10'd0}, 1, nil});
		// key 1021 -> base 0
		rows.push_back('{'{dhkt_pkg::CMD_INSERT, 32'd1021, '1, 10'd0}, 1,
			'{1'b1, 10'd0, 32'd1021, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1}});
		rows.push_back('{'{dhkt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 64'd0, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 64'h1234, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_INSERT, 32'd2042, 64'hA5A5, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_LOOKUP, 32'd2042, 64'd0, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_READ, 32'hDEAD, 64'd0, 10'd0}, 1,
			'{1'b1, 10'd0, 32'd1021, 64'hFFFF_FFFF_FFFF_FFFF, 10'd3}});
		rows.push_back('{'{dhkt_pkg::CMD_READ, 32'd0, 64'd0, 10'd1020}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_READ, 32'd0, 64'd0, 10'd1021}, 1,
			'{1'b0, 10'd0, 32'd0, 64'd0, 10'd3}});
		rows.push_back('{'{dhkt_pkg::CMD_READ, 32'd0, 64'd0, 10'd1023}, 1,
			'{1'b0, 10'd0, 32'd0, 64'd0, 10'd3}});
		// duplicate key: open a hole before 2042, then reinsert
		rows.push_back('{'{dhkt_pkg::CMD_REMOVE, 32'd1021, 64'd0, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_INSERT, 32'd2042, 64'h5A5A, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_LOOKUP, 32'd2042, 64'd0, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_REMOVE, 32'd2042, 64'd0, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_LOOKUP, 32'd2042, 64'd0, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 64'd0, 10'd0}, 0, nil});
		rows.push_back('{'{dhkt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 64'd0, 10'd0}, 0, nil});
		repeat (3) @(posedge clk);
		arst_n <= 1;
		foreach (rows[i]) send_op(rows[i].op, rows[i].fixed, rows[i].resp);
		// random mix; keys reused so hits, duplicates and removals happen
		for (int n = 0; n < 1000; n++) begin
			if (n == 500) wait_drained();
			roll = $urandom_range(0, 99);
			op.cmd = roll < 40 ? dhkt_pkg::CMD_INSERT : roll < 65 ? dhkt_pkg::CMD_LOOKUP :
				roll < 85 ? dhkt_pkg::CMD_REMOVE : dhkt_pkg::CMD_READ;
			op.key = $urandom_range(0, 40) == 0 ? 32'd0 : pick_key();
			op.value = {$urandom(), $urandom()};
			op.slot_in = $urandom_range(0, 7) == 0 ? 10'($urandom_range(1021, 1023)) :
				10'($urandom_range(0, 1020));
			if (op.cmd == dhkt_pkg::CMD_INSERT && op.key != 0 && used_keys.size() < 300)
				used_keys.push_back(op.key);
			send_op(op, 0, nil);
		end
		// fill the table to full so insert fails; ready held high to keep it quick
		wait_drained();
		hard_mode = 1;
		while (tbl_count < dhkt_pkg::TableSlots) begin
			op = '{dhkt_pkg::CMD_INSERT, $urandom() | 32'h1, {$urandom(), $urandom()}, 10'd0};
			send_op(op, 0, nil);
		end
		for (int n = 0; n < 6; n++) begin
			op = '{dhkt_pkg::CMD_INSERT, $urandom() | 32'h2, 64'd9, 10'd0};
			send_op(op, 0, nil);
			op = '{dhkt_pkg::CMD_READ, 32'd0, 64'd0, 10'($urandom_range(0, 1020))};
			send_op(op, 0, nil);
		end
		wait_drained();
		repeat (100) @(posedge clk);
		$display("Sent %0d requests (directed, random mix, fill to full); %0d responses checked.",
			sent, resp_seen);
		if (fail_count == 0 && pending_resp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

### filelist.f
src/dhkt_pkg.sv
src/dhkt_ram.sv
src/dhkt_front.sv
src/dhkt_back.sv
src/double_hash_key_table.sv
sim/double_hash_key_table_test.sv
